>>> src/esc_pkg.sv
package esc_pkg;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } esc_in_t;

  typedef struct packed {
    logic signed [14:0] temperature;
    logic [24:0]        pressure;
    logic [16:0]        humidity;
    logic               pressure_invalid;
  } esc_out_t;

  // Low half of a 64x64 product, split into partial products.
  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] cr;
  } pp_t;

  localparam int unsigned EscLatency = 86;

  localparam logic signed [14:0] TempMin  = -15'sd4000;
  localparam logic signed [14:0] TempMax  = 15'sd8500;
  localparam logic [24:0]        PressMin = 25'd7680000;
  localparam logic [24:0]        PressMax = 25'd28160000;
  localparam logic [16:0]        HumMax   = 17'd102400;

  function automatic pp_t mul_pp(input logic [63:0] a, input logic [63:0] b);
    pp_t p;
    p.ll = 64'(a[31:0]) * 64'(b[31:0]);
    p.cr = 32'(a[63:32] * b[31:0]) + 32'(a[31:0] * b[63:32]);
    return p;
  endfunction

  function automatic logic [63:0] mul_sum(input pp_t p);
    return p.ll + {p.cr, 32'd0};
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] v, input int unsigned n);
    return 64'($signed(v) >>> n);
  endfunction

endpackage

>>> src/esc_div.sv
module esc_div #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 31,
  parameter int unsigned TagW = 17
) (
  input  logic            clk_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  logic [TagW-1:0] tag_i,
  output logic [NumW-1:0] quo_o,
  output logic [TagW-1:0] tag_o
);

  // One quotient bit per stage: work word shifts dividend out, quotient in.
  logic [NumW-1:0] w_q [NumW+1];
  logic [DenW-1:0] r_q [NumW+1];
  logic [DenW-1:0] d_q [NumW+1];
  logic [TagW-1:0] t_q [NumW+1];

  always_ff @(posedge clk_i) begin
    w_q[0] <= num_i;
    r_q[0] <= '0;
    d_q[0] <= den_i;
    t_q[0] <= tag_i;
  end

  for (genvar k = 1; k <= NumW; k++) begin : g_step
    logic [DenW:0] trial;
    logic [DenW:0] diff;
    logic          ge;

    assign trial = {r_q[k-1], w_q[k-1][NumW-1]};
    assign diff  = trial - {1'b0, d_q[k-1]};
    assign ge    = (trial >= {1'b0, d_q[k-1]});

    always_ff @(posedge clk_i) begin
      r_q[k] <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
      w_q[k] <= {w_q[k-1][NumW-2:0], ge};
      d_q[k] <= d_q[k-1];
      t_q[k] <= t_q[k-1];
    end
  end

  assign quo_o = w_q[NumW];
  assign tag_o = t_q[NumW];

endmodule

>>> src/env_sensor_compensation.sv
// Trim compensation for a barometric temperature/pressure/humidity sensor.
// Write the five trim registers while no item is in flight, then pulse start
// with a raw triple; an item is taken at every clock edge where start is high,
// one per cycle with no gaps needed (busy stays low). Each result appears on
// res_o for exactly one cycle, flagged by res_strobe_o; results leave in
// order and cannot be held off, so capture them on the strobe. Most of the
// pipeline is the pressure division: a 64-bit signed quotient worked out one
// bit per stage over 64 stages, plus the multiply stages before and after it.
// All arithmetic wraps at 64 bits.
module env_sensor_compensation (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  esc_pkg::esc_in_t  in_i,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [63:0]       cfg_data_i,
  output logic              res_strobe_o,
  output esc_pkg::esc_out_t res_o
);

  localparam logic [2:0] RegTempTrim  = 3'd0;
  localparam logic [2:0] RegPressTrimA = 3'd1;
  localparam logic [2:0] RegPressTrimB = 3'd2;
  localparam logic [2:0] RegMixedTrim = 3'd3;
  localparam logic [2:0] RegHumTrim   = 3'd4;

  typedef struct packed {
    logic               neg;
    logic               bad;
    logic signed [14:0] temp;
  } tag_t;

  // ---------------------------------------------------------------------------
  // Trim registers
  // ---------------------------------------------------------------------------
  logic [47:0] temp_trim_q;
  logic [63:0] press_a_q;
  logic [63:0] press_b_q;
  logic [47:0] mixed_q;
  logic [31:0] hum_trim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_trim_q <= '0;
      press_a_q   <= '0;
      press_b_q   <= '0;
      mixed_q     <= '0;
      hum_trim_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegTempTrim:   temp_trim_q <= cfg_data_i[47:0];
        RegPressTrimA: press_a_q   <= cfg_data_i;
        RegPressTrimB: press_b_q   <= cfg_data_i;
        RegMixedTrim:  mixed_q     <= cfg_data_i[47:0];
        RegHumTrim:    hum_trim_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Unpack the coefficients.
  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
  logic [7:0]         h1, h3;
  logic signed [11:0] h4, h5;
  logic signed [7:0]  h6;

  assign t1 = temp_trim_q[15:0];
  assign t2 = $signed(temp_trim_q[31:16]);
  assign t3 = $signed(temp_trim_q[47:32]);
  assign p1 = press_a_q[15:0];
  assign p2 = $signed(press_a_q[31:16]);
  assign p3 = $signed(press_a_q[47:32]);
  assign p4 = $signed(press_a_q[63:48]);
  assign p5 = $signed(press_b_q[15:0]);
  assign p6 = $signed(press_b_q[31:16]);
  assign p7 = $signed(press_b_q[47:32]);
  assign p8 = $signed(press_b_q[63:48]);
  assign p9 = $signed(mixed_q[15:0]);
  assign h1 = mixed_q[23:16];
  assign h2 = $signed(mixed_q[39:24]);
  assign h3 = mixed_q[47:40];
  assign h4 = $signed(hum_trim_q[11:0]);
  assign h5 = $signed(hum_trim_q[23:12]);
  assign h6 = $signed(hum_trim_q[31:24]);

  // ---------------------------------------------------------------------------
  // Valid line: the pipeline never stalls, so validity just shifts along.
  // ---------------------------------------------------------------------------
  logic                                accept;
  logic [esc_pkg::EscLatency-1:0]      vld_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[esc_pkg::EscLatency-2:0], accept};
    end
  end

  // ---------------------------------------------------------------------------
  // Temperature and fine term (stages 1..6)
  // ---------------------------------------------------------------------------
  logic signed [18:0] a1_q;
  logic signed [17:0] b1_q;
  logic [19:0]        adcp_q [1:10];
  logic [15:0]        adch_q [1:7];
  logic signed [34:0] ma2_q;
  logic signed [35:0] bb2_q;
  logic signed [23:0] v13_q;
  logic signed [37:0] mb3_q;
  logic signed [25:0] tf4_q;
  logic signed [28:0] t5_q;
  logic [63:0]        xp5_q, xh5_q;
  logic signed [21:0] bbs;
  logic signed [28:0] ts;
  logic signed [14:0] temp_d;

  assign bbs = 22'(bb2_q >>> 12);
  assign ts  = t5_q >>> 8;

  always_comb begin
    if (ts < 29'(esc_pkg::TempMin)) begin
      temp_d = esc_pkg::TempMin;
    end else if (ts > 29'(esc_pkg::TempMax)) begin
      temp_d = esc_pkg::TempMax;
    end else begin
      temp_d = ts[14:0];
    end
  end

  logic signed [14:0] temp_q [6:13];

  always_ff @(posedge clk_i) begin
    a1_q  <= $signed({2'b00, in_i.raw_temperature[19:3]}) - $signed({2'b00, t1, 1'b0});
    b1_q  <= $signed({2'b00, in_i.raw_temperature[19:4]}) - $signed({2'b00, t1});
    adcp_q[1] <= in_i.raw_pressure;
    adch_q[1] <= in_i.raw_humidity;
    for (int k = 2; k <= 10; k++) adcp_q[k] <= adcp_q[k-1];
    for (int k = 2; k <= 7; k++)  adch_q[k] <= adch_q[k-1];
    ma2_q <= a1_q * t2;
    bb2_q <= b1_q * b1_q;
    v13_q <= 24'(ma2_q >>> 11);
    mb3_q <= bbs * t3;
    tf4_q <= 26'(v13_q) + 26'(mb3_q >>> 14);
    t5_q  <= tf4_q * 29'sd5;
    xp5_q <= 64'(tf4_q) - 64'd128000;
    xh5_q <= 64'(tf4_q) - 64'd76800;
    temp_q[6] <= temp_d;
    for (int k = 7; k <= 13; k++) temp_q[k] <= temp_q[k-1];
  end

  // ---------------------------------------------------------------------------
  // Pressure up to the divider (stages 6..13)
  // ---------------------------------------------------------------------------
  esc_pkg::pp_t pp_xx6_q, pp_xp5_6_q, pp_xp2_6_q, pp_hx6_q, pp_xh6_6_q, pp_xh3_6_q;
  logic [63:0]  xx7_q, xp5_7_q, xp2_7_q, hx7_q, xh6_7_q, xh3_7_q;
  esc_pkg::pp_t pp_v2a8_q, pp_v1a8_q;
  logic [63:0]  xp5_8_q, xp2_8_q, xp5_9_q, xp2_9_q;
  logic [63:0]  v2a9_q, v1a9_q, v2_10_q, v1s10_q;
  esc_pkg::pp_t pp_v1m11_q, pp_num12_q;
  logic [63:0]  pnum11_q, v1m12_q, num13_q;
  logic         bad13_q;
  logic [30:0]  den13_q;
  logic [20:0]  pn;
  logic [63:0]  v1;

  assign pn = 21'd1048576 - {1'b0, adcp_q[10]};
  assign v1 = esc_pkg::asr64(v1m12_q, 33);

  always_ff @(posedge clk_i) begin
    pp_xx6_q   <= esc_pkg::mul_pp(xp5_q, xp5_q);
    pp_xp5_6_q <= esc_pkg::mul_pp(xp5_q, 64'(p5));
    pp_xp2_6_q <= esc_pkg::mul_pp(xp5_q, 64'(p2));
    pp_hx6_q   <= esc_pkg::mul_pp(xh5_q, 64'(h5));
    pp_xh6_6_q <= esc_pkg::mul_pp(xh5_q, 64'(h6));
    pp_xh3_6_q <= esc_pkg::mul_pp(xh5_q, 64'(h3));
    xx7_q   <= esc_pkg::mul_sum(pp_xx6_q);
    xp5_7_q <= esc_pkg::mul_sum(pp_xp5_6_q);
    xp2_7_q <= esc_pkg::mul_sum(pp_xp2_6_q);
    hx7_q   <= esc_pkg::mul_sum(pp_hx6_q);
    xh6_7_q <= esc_pkg::mul_sum(pp_xh6_6_q);
    xh3_7_q <= esc_pkg::mul_sum(pp_xh3_6_q);
    pp_v2a8_q <= esc_pkg::mul_pp(xx7_q, 64'(p6));
    pp_v1a8_q <= esc_pkg::mul_pp(xx7_q, 64'(p3));
    xp5_8_q <= xp5_7_q;
    xp2_8_q <= xp2_7_q;
    v2a9_q  <= esc_pkg::mul_sum(pp_v2a8_q);
    v1a9_q  <= esc_pkg::mul_sum(pp_v1a8_q);
    xp5_9_q <= xp5_8_q;
    xp2_9_q <= xp2_8_q;
    v2_10_q  <= v2a9_q + (xp5_9_q << 17) + (64'(p4) << 35);
    v1s10_q  <= esc_pkg::asr64(v1a9_q, 8) + (xp2_9_q << 12) + (64'd1 << 47);
    pp_v1m11_q <= esc_pkg::mul_pp(v1s10_q, 64'(p1));
    pnum11_q   <= (64'(pn) << 31) - v2_10_q;
    v1m12_q    <= esc_pkg::mul_sum(pp_v1m11_q);
    pp_num12_q <= esc_pkg::mul_pp(pnum11_q, 64'd3125);
    // Divisor not positive: pressure will be forced to its minimum.
    bad13_q <= ($signed(v1) <= 64'sd0);
    den13_q <= v1[30:0];
    num13_q <= esc_pkg::mul_sum(pp_num12_q);
  end

  // ---------------------------------------------------------------------------
  // Divider: magnitude in, sign and side data ride along as the tag.
  // ---------------------------------------------------------------------------
  tag_t        div_tag_in, div_tag_out;
  logic [63:0] div_num, div_quo;

  assign div_tag_in.neg  = num13_q[63];
  assign div_tag_in.bad  = bad13_q;
  assign div_tag_in.temp = temp_q[13];
  assign div_num         = num13_q[63] ? (~num13_q + 64'd1) : num13_q;

  esc_div #(
    .NumW(64),
    .DenW(31),
    .TagW($bits(tag_t))
  ) u_div (
    .clk_i (clk_i),
    .num_i (div_num),
    .den_i (den13_q),
    .tag_i (div_tag_in),
    .quo_o (div_quo),
    .tag_o (div_tag_out)
  );

  // ---------------------------------------------------------------------------
  // Humidity (stages 8..23), then hold until the pressure catches up.
  // ---------------------------------------------------------------------------
  logic [63:0]  ha_q [8:14];
  logic [63:0]  hb8_q, hc8_q, bc10_q, c11_q, ch13_q, c14_q;
  esc_pkg::pp_t pp_bc9_q, pp_ch12_q, pp_hum15_q, pp_sq17_q, pp_r20_q;
  logic [63:0]  hum_q [16:21];
  logic [63:0]  sq18_q, sq7_19_q, r21_q, hum22_q;
  logic [16:0]  humc23_q;
  logic [16:0]  hl_q [24:85];
  logic [28:0]  hcl;

  always_comb begin
    if ($signed(hum22_q) < 64'sd0) begin
      hcl = '0;
    end else if ($signed(hum22_q) > 64'sd419430400) begin
      hcl = 29'd419430400;
    end else begin
      hcl = hum22_q[28:0];
    end
  end

  always_ff @(posedge clk_i) begin
    ha_q[8] <= (64'(adch_q[7]) << 14) - (64'(h4) << 20) - hx7_q + 64'd16384;
    for (int k = 9; k <= 14; k++) ha_q[k] <= ha_q[k-1];
    hb8_q <= esc_pkg::asr64(xh6_7_q, 10);
    hc8_q <= esc_pkg::asr64(xh3_7_q, 11) + 64'd32768;
    pp_bc9_q  <= esc_pkg::mul_pp(hb8_q, hc8_q);
    bc10_q    <= esc_pkg::mul_sum(pp_bc9_q);
    c11_q     <= esc_pkg::asr64(bc10_q, 10) + 64'd2097152;
    pp_ch12_q <= esc_pkg::mul_pp(c11_q, 64'(h2));
    ch13_q    <= esc_pkg::mul_sum(pp_ch12_q);
    c14_q     <= esc_pkg::asr64(ch13_q + 64'd8192, 14);
    pp_hum15_q <= esc_pkg::mul_pp(esc_pkg::asr64(ha_q[14], 15), c14_q);
    hum_q[16]  <= esc_pkg::mul_sum(pp_hum15_q);
    for (int k = 17; k <= 21; k++) hum_q[k] <= hum_q[k-1];
    pp_sq17_q <= esc_pkg::mul_pp(esc_pkg::asr64(hum_q[16], 15),
                                 esc_pkg::asr64(hum_q[16], 15));
    sq18_q    <= esc_pkg::mul_sum(pp_sq17_q);
    sq7_19_q  <= esc_pkg::asr64(sq18_q, 7);
    pp_r20_q  <= esc_pkg::mul_pp(sq7_19_q, 64'(h1));
    r21_q     <= esc_pkg::mul_sum(pp_r20_q);
    hum22_q   <= hum_q[21] - esc_pkg::asr64(r21_q, 4);
    humc23_q  <= 17'(hcl >> 12);
    hl_q[24]  <= humc23_q;
    for (int k = 25; k <= 85; k++) hl_q[k] <= hl_q[k-1];
  end

  // ---------------------------------------------------------------------------
  // Pressure tail after the divider (stages 79..85)
  // ---------------------------------------------------------------------------
  tag_t         side_q [79:85];
  logic [63:0]  p79_q, p80_q, p81_q, p82_q, p83_q;
  logic [63:0]  ps80_q, ps81_q, m1_81_q, m2_81_q, w2_82_q, w2_83_q, w1s83_q;
  logic [63:0]  sum84_q, pr85_q, ps79;
  esc_pkg::pp_t pp_a80_q, pp_b80_q, pp_w82_q;

  assign ps79 = esc_pkg::asr64(p79_q, 13);

  always_ff @(posedge clk_i) begin
    p79_q     <= div_tag_out.neg ? (~div_quo + 64'd1) : div_quo;
    side_q[79] <= div_tag_out;
    for (int k = 80; k <= 85; k++) side_q[k] <= side_q[k-1];
    pp_a80_q <= esc_pkg::mul_pp(64'(p9), ps79);
    pp_b80_q <= esc_pkg::mul_pp(64'(p8), p79_q);
    p80_q    <= p79_q;
    ps80_q   <= ps79;
    m1_81_q  <= esc_pkg::mul_sum(pp_a80_q);
    m2_81_q  <= esc_pkg::mul_sum(pp_b80_q);
    p81_q    <= p80_q;
    ps81_q   <= ps80_q;
    pp_w82_q <= esc_pkg::mul_pp(m1_81_q, ps81_q);
    w2_82_q  <= esc_pkg::asr64(m2_81_q, 19);
    p82_q    <= p81_q;
    w1s83_q  <= esc_pkg::mul_sum(pp_w82_q);
    w2_83_q  <= w2_82_q;
    p83_q    <= p82_q;
    sum84_q  <= p83_q + esc_pkg::asr64(w1s83_q, 25) + w2_83_q;
    pr85_q   <= esc_pkg::asr64(sum84_q, 8) + (64'(p7) << 4);
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  esc_pkg::esc_out_t res_d, res_q;

  always_comb begin
    res_d.temperature      = side_q[85].temp;
    res_d.humidity         = hl_q[85];
    res_d.pressure_invalid = side_q[85].bad;
    priority if (side_q[85].bad) begin
      res_d.pressure = esc_pkg::PressMin;
    end else if ($signed(pr85_q) < $signed(64'(esc_pkg::PressMin))) begin
      res_d.pressure = esc_pkg::PressMin;
    end else if ($signed(pr85_q) > $signed(64'(esc_pkg::PressMax))) begin
      res_d.pressure = esc_pkg::PressMax;
    end else begin
      res_d.pressure = pr85_q[24:0];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o        = res_q;
  assign res_strobe_o = vld_q[esc_pkg::EscLatency-1];

endmodule

>>> src/esc_checker.sv
module esc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              res_strobe_o,
  input esc_pkg::esc_out_t res_o
);

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(esc_pkg::EscLatency) res_strobe_o)
    else $error("result missing after item");

  a_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> $past(start && !busy, esc_pkg::EscLatency))
    else $error("result without item");

  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> (res_o.temperature >= esc_pkg::TempMin &&
                      res_o.temperature <= esc_pkg::TempMax &&
                      res_o.pressure >= esc_pkg::PressMin &&
                      res_o.pressure <= esc_pkg::PressMax &&
                      res_o.humidity <= esc_pkg::HumMax))
    else $error("result out of range");

  a_invalid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.pressure_invalid) |-> (res_o.pressure == esc_pkg::PressMin))
    else $error("invalid pressure not at minimum");

endmodule

bind env_sensor_compensation esc_checker u_esc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .res_strobe_o (res_strobe_o),
  .res_o        (res_o)
);

>>> test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Register indexes of the trim write port.
  localparam logic [2:0] RegTempTrim   = 3'd0;
  localparam logic [2:0] RegPressTrimA = 3'd1;
  localparam logic [2:0] RegPressTrimB = 3'd2;
  localparam logic [2:0] RegMixedTrim  = 3'd3;
  localparam logic [2:0] RegHumTrim    = 3'd4;

  // Trim setups the run walks through.
  typedef enum int {
    TrimTypical, TrimJitter, TrimRandom, TrimAllOnes, TrimZero, TrimSignedMax
  } trim_mode_e;

  localparam int unsigned CycleLimit = 400000;

  logic     clk_i, rst_ni, start, busy, cfg_we_i, res_strobe_o;
  esc_pkg::esc_in_t  in_i;
  esc_pkg::esc_out_t res_o;
  logic [2:0]  cfg_index_i;
  logic [63:0] cfg_data_i;

  env_sensor_compensation uut (
    .clk_i, .rst_ni, .start, .busy, .in_i,
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .res_strobe_o, .res_o
  );

  // Local copy of the trim registers, as the block should hold them.
  logic [47:0] temp_trim_q;
  logic [63:0] press_a_q, press_b_q;
  logic [47:0] mixed_trim_q;
  logic [31:0] hum_trim_q;

  esc_pkg::esc_out_t pending_readings[$];
  int unsigned mismatches, readings_sent, readings_seen, burst_left, cycles;

  // Directed stimulus: field extremes and typical values. The want column
  // holds the result with all trims at reset: zero temperature, pressure
  // forced to its floor with the invalid flag, zero humidity.
  typedef struct {
    esc_pkg::esc_in_t  stim;
    esc_pkg::esc_out_t want;
  } directed_row_t;

  localparam esc_pkg::esc_out_t ResetResult = '{temperature: '0,
                                                pressure: esc_pkg::PressMin,
                                                humidity: '0,
                                                pressure_invalid: 1'b1};

  directed_row_t directed_rows[] = '{
    '{'{20'h00000, 20'h00000, 16'h0000}, ResetResult},
    '{'{20'hFFFFF, 20'hFFFFF, 16'hFFFF}, ResetResult},
    '{'{20'hFFFFF, 20'h00000, 16'h0000}, ResetResult},
    '{'{20'h00000, 20'hFFFFF, 16'hFFFF}, ResetResult},
    '{'{20'd519888, 20'd415148, 16'd30000}, ResetResult},
    '{'{20'd519888, 20'd0, 16'd0}, ResetResult},
    '{'{20'd519888, 20'hFFFFF, 16'hFFFF}, ResetResult},
    '{'{20'd300000, 20'd600000, 16'd20000}, ResetResult},
    '{'{20'd700000, 20'd250000, 16'd45000}, ResetResult},
    '{'{20'h80000, 20'h80000, 16'h8000}, ResetResult},
    '{'{20'h7FFFF, 20'h7FFFF, 16'h7FFF}, ResetResult},
    '{'{20'hAAAAA, 20'h55555, 16'hAAAA}, ResetResult},
    '{'{20'h55555, 20'hAAAAA, 16'h5555}, ResetResult}
  };

  // Compensate one raw triple with the current trims; all math wraps at 64 bits.
  function automatic esc_pkg::esc_out_t compensate(esc_pkg::esc_in_t s);
    longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint h1, h2, h3, h4, h5, h6;
    longint adc_t, adc_p, adc_h, a, b, c, fine, x, v1, v2, w1, w2, pr, hm, tc;
    esc_pkg::esc_out_t r;
    adc_t = s.raw_temperature;
    adc_p = s.raw_pressure;
    adc_h = s.raw_humidity;
    t1 = temp_trim_q[15:0];           t2 = $signed(temp_trim_q[31:16]);
    t3 = $signed(temp_trim_q[47:32]);
    p1 = press_a_q[15:0];             p2 = $signed(press_a_q[31:16]);
    p3 = $signed(press_a_q[47:32]);   p4 = $signed(press_a_q[63:48]);
    p5 = $signed(press_b_q[15:0]);    p6 = $signed(press_b_q[31:16]);
    p7 = $signed(press_b_q[47:32]);   p8 = $signed(press_b_q[63:48]);
    p9 = $signed(mixed_trim_q[15:0]); h1 = mixed_trim_q[23:16];
    h2 = $signed(mixed_trim_q[39:24]); h3 = mixed_trim_q[47:40];
    h4 = $signed(hum_trim_q[11:0]);   h5 = $signed(hum_trim_q[23:12]);
    h6 = $signed(hum_trim_q[31:24]);

    // temperature and fine term
    a    = (adc_t >>> 3) - t1 * 2;
    v1   = (a * t2) >>> 11;
    b    = (adc_t >>> 4) - t1;
    v2   = (((b * b) >>> 12) * t3) >>> 14;
    fine = v1 + v2;
    tc   = (fine * 5) >>> 8;
    if (tc < -4000) tc = -4000;
    else if (tc > 8500) tc = 8500;
    r.temperature = tc[14:0];

    // pressure; a divisor at or below zero forces the floor and the flag
    x  = fine - 128000;
    v2 = x * x * p6;
    v2 = v2 + ((x * p5) <<< 17);
    v2 = v2 + (p4 <<< 35);
    v1 = (((x * x) * p3) >>> 8) + ((x * p2) <<< 12);
    v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
    if (v1 <= 0) begin
      r.pressure_invalid = 1'b1;
      pr = esc_pkg::PressMin;
    end else begin
      r.pressure_invalid = 1'b0;
      pr = 1048576 - adc_p;
      pr = (((pr <<< 31) - v2) * 3125) / v1;
      w1 = ((p9 * (pr >>> 13)) * (pr >>> 13)) >>> 25;
      w2 = (p8 * pr) >>> 19;
      pr = ((pr + w1 + w2) >>> 8) + (p7 <<< 4);
      if (pr < 7680000) pr = 7680000;
      else if (pr > 28160000) pr = 28160000;
    end
    r.pressure = pr[24:0];

    // humidity
    x  = fine - 76800;
    a  = (adc_h <<< 14) - (h4 <<< 20) - h5 * x;
    a  = (a + 16384) >>> 15;
    b  = (x * h6) >>> 10;
    c  = ((x * h3) >>> 11) + 32768;
    c  = ((b * c) >>> 10) + 2097152;
    c  = ((c * h2) + 8192) >>> 14;
    hm = a * c;
    hm = hm - (((((hm >>> 15) * (hm >>> 15)) >>> 7) * h1) >>> 4);
    if (hm < 0) hm = 0;
    else if (hm > 419430400) hm = 419430400;
    hm = hm >>> 12;
    r.humidity = hm[16:0];
    return r;
  endfunction

  // Clock and cycle limit.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d readings outstanding", cycles,
               pending_readings.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Results cannot be held off: check each one on its strobe.
  always @(posedge clk_i) begin
    esc_pkg::esc_out_t want;
    if (rst_ni && res_strobe_o) begin
      readings_seen++;
      if (pending_readings.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected reading %p", $realtime, res_o);
      end else begin
        want = pending_readings.pop_front();
        if (res_o.temperature !== want.temperature) begin
          mismatches++;
          $display("%0t: temperature expected %0d got %0d", $realtime,
                   want.temperature, res_o.temperature);
        end
        if (res_o.pressure !== want.pressure) begin
          mismatches++;
          $display("%0t: pressure expected %0d got %0d", $realtime,
                   want.pressure, res_o.pressure);
        end
        if (res_o.humidity !== want.humidity) begin
          mismatches++;
          $display("%0t: humidity expected %0d got %0d", $realtime,
                   want.humidity, res_o.humidity);
        end
        if (res_o.pressure_invalid !== want.pressure_invalid) begin
          mismatches++;
          $display("%0t: pressure_invalid expected %0b got %0b", $realtime,
                   want.pressure_invalid, res_o.pressure_invalid);
        end
      end
    end
  end

  // Offer one item; senders work in bursts with random gaps in between.
  task automatic send_reading(esc_pkg::esc_in_t s, bit typed, esc_pkg::esc_out_t want);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    start <= 1'b1;
    in_i  <= s;
    do @(posedge clk_i); while (busy);
    // the item was taken at this edge
    pending_readings.push_back(typed ? want : compensate(s));
    readings_sent++;
  endtask

  // Drop start and hold until every expected reading has come back.
  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    burst_left = 0;
  endtask

  function automatic logic [15:0] jitter(logic [15:0] v, int span);
    return v + 16'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // Write all five trims back to back; only called with nothing in flight.
  task automatic load_trims(trim_mode_e mode);
    logic [63:0] regs[5];
    logic [15:0] f[18];
    // typical per-chip trims: T1..T3, P1..P9, H1..H6
    f = '{16'd27504, 16'd26435, -16'sd1000, 16'd36477, -16'sd10685, 16'd3024,
          16'd2855, 16'd140, -16'sd7, 16'd15500, -16'sd14600, 16'd6000,
          16'd75, 16'd362, 16'd0, 16'd313, 16'd50, 16'd30};
    if (mode == TrimJitter)
      foreach (f[k]) f[k] = jitter(f[k], 40);
    regs[0] = {16'($urandom), f[2], f[1], f[0]};
    regs[1] = {f[6], f[5], f[4], f[3]};
    regs[2] = {f[10], f[9], f[8], f[7]};
    regs[3] = {16'($urandom), f[17][7:0] ^ f[14][7:0], f[13], f[12][7:0], f[11]};
    regs[3][47:40] = f[14][7:0];
    regs[4] = {$urandom, f[17][7:0], f[16][11:0], f[15][11:0]};
    case (mode)
      TrimRandom:    foreach (regs[k]) regs[k] = {$urandom, $urandom};
      TrimAllOnes:   foreach (regs[k]) regs[k] = '1;
      TrimZero:      foreach (regs[k]) regs[k] = '0;
      TrimSignedMax: begin
        regs[0] = 64'({16'h7FFF, 16'h7FFF, 16'hFFFF});
        regs[1] = {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF};
        regs[2] = {4{16'h7FFF}};
        regs[3] = 64'({8'hFF, 16'h7FFF, 8'hFF, 16'h7FFF});
        regs[4] = 64'({8'h7F, 12'h7FF, 12'h7FF});
      end
      default: ;
    endcase
    cfg_we_i <= 1'b1;
    foreach (regs[k]) begin
      cfg_index_i <= 3'(k);
      cfg_data_i  <= regs[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    temp_trim_q  = regs[RegTempTrim][47:0];
    press_a_q    = regs[RegPressTrimA];
    press_b_q    = regs[RegPressTrimB];
    mixed_trim_q = regs[RegMixedTrim][47:0];
    hum_trim_q   = regs[RegHumTrim][31:0];
  endtask

  // Mostly plausible converter values, the rest anywhere in range.
  function automatic esc_pkg::esc_in_t pick_reading();
    esc_pkg::esc_in_t s;
    if ($urandom_range(0, 9) < 7) begin
      s.raw_temperature = 20'($urandom_range(380000, 660000));
      s.raw_pressure    = 20'($urandom_range(200000, 500000));
      s.raw_humidity    = 16'($urandom_range(15000, 45000));
    end else begin
      s = esc_pkg::esc_in_t'(56'({$urandom, $urandom}));
      if ($urandom_range(0, 3) == 0) s.raw_temperature = $urandom_range(0, 1) ? '1 : '0;
      if ($urandom_range(0, 3) == 0) s.raw_pressure    = $urandom_range(0, 1) ? '1 : '0;
      if ($urandom_range(0, 3) == 0) s.raw_humidity    = $urandom_range(0, 1) ? '1 : '0;
    end
    return s;
  endfunction

  initial begin
    trim_mode_e plan[] = '{TrimTypical, TrimJitter, TrimRandom, TrimAllOnes,
                           TrimJitter, TrimZero, TrimSignedMax, TrimRandom};
    cycles = 0;  mismatches = 0;  readings_sent = 0;  readings_seen = 0;
    burst_left = 0;
    rst_ni = 1'b0;  start = 1'b0;  in_i = '0;
    cfg_we_i = 1'b0;  cfg_index_i = RegTempTrim;  cfg_data_i = '0;
    temp_trim_q = '0;  press_a_q = '0;  press_b_q = '0;
    mixed_trim_q = '0;  hum_trim_q = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset trims: every row must come back with the fixed reset result.
    foreach (directed_rows[k]) send_reading(directed_rows[k].stim, 1'b1,
                                            directed_rows[k].want);
    drain();

    // Same rows under typical, jittered, random and all-ones trims, against the predictor.
    foreach (plan[m]) begin
      if (m > 3) break;
      load_trims(plan[m]);
      foreach (directed_rows[k]) send_reading(directed_rows[k].stim, 1'b0, ResetResult);
      drain();
    end

    // Random phases, one trim setup each.
    foreach (plan[m]) begin
      load_trims(plan[m]);
      for (int n = 0; n < 115; n++) begin
        send_reading(pick_reading(), 1'b0, ResetResult);
        // in the second phase only, hold off once mid-phase until the pipe has emptied
        if (m == 1 && n == 57) drain();
      end
      drain();
    end

    repeat (esc_pkg::EscLatency + 10) @(posedge clk_i);
    $display("Sent %0d readings, checked %0d, across reset, typical, jittered,",
             readings_sent, readings_seen);
    $display("random, all-ones, zero and signed-max trim setups.");
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d readings missing", mismatches,
               pending_readings.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
